FILE: design/cbnt_pkg.sv
// Shared types, operation codes, register map and reset values for the channel busy tracker.
package cbnt_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned ADDR48_W   = 48;
  localparam int unsigned RSS_W      = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  // Event codes.
  localparam op_t OP_TICK       = 3'd0;
  localparam op_t OP_TX_START   = 3'd1;
  localparam op_t OP_TX_END     = 3'd2;
  localparam op_t OP_RX_START   = 3'd3;
  localparam op_t OP_RX_END     = 3'd4;
  localparam op_t OP_FRAME_RX   = 3'd5;
  localparam op_t OP_RSS_CHANGE = 3'd6;

  // Register indexes; register i sits at byte address 4*i.
  localparam reg_idx_t REG_EN_OWN_TX   = 3'd0;
  localparam reg_idx_t REG_EN_OWN_RX   = 3'd1;
  localparam reg_idx_t REG_EN_CS       = 3'd2;
  localparam reg_idx_t REG_EN_NAV      = 3'd3;
  localparam reg_idx_t REG_THRESHOLD   = 3'd4;
  localparam reg_idx_t REG_SHORT_GAP   = 3'd5;
  localparam reg_idx_t REG_PERIOD      = 3'd6;

  localparam logic signed [RSS_W-1:0] THRESHOLD_RST = -16'sd328;
  localparam logic [DUR_W-1:0]        SHORT_GAP_RST = 16'd10;
  localparam logic [CNT_W-1:0]        PERIOD_RST    = 32'd1000000;
  localparam logic signed [RSS_W-1:0] RSS_RST       = 16'sh8000;

endpackage

FILE: design/channel_busy_nav_tracker.sv
// Channel busy tracker with NAV countdown and busy-tick accounting per period.
//
//  Channel | Ports                              | Direction | Transaction
//  --------+------------------------------------+-----------+------------------------------
//  in      | in_valid/in_ready, in_<field>      | input     | one MAC event
//  out     | out_valid/out_ready, out_<field>   | output    | one result per event
//  cfg     | psel/penable/pwrite/paddr/pwdata.. | APB       | register write or read
//
// Each event is processed in the cycle it is accepted; its result appears in the output register
// in the next cycle, and one event per cycle is sustained while out_ready stays high.
// in_ready is high whenever the output register is empty or being drained this cycle.
// A stall on out_ready holds the result and back-pressures the input after one item.
// Reset (rst_n low, synchronous) restores register defaults and resets all tracking state.
module channel_busy_nav_tracker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // event channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [cbnt_pkg::OP_W-1:0]              in_operation,
  input  logic [cbnt_pkg::DUR_W-1:0]             in_duration,
  input  logic                                   in_has_payload,
  input  logic                                   in_ack_for_me,
  input  logic [cbnt_pkg::ADDR48_W-1:0]          in_sender_address,
  input  logic signed [cbnt_pkg::RSS_W-1:0]      in_signal_strength,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_channel_busy,
  output logic                                   out_state_changed,
  output logic                                   out_nav_started,
  output logic                                   out_nav_ended,
  output logic [cbnt_pkg::ADDR48_W-1:0]          out_nav_owner,
  output logic                                   out_period_done,
  output logic [cbnt_pkg::CNT_W-1:0]             out_busy_count,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cbnt_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [cbnt_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [cbnt_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  // Configuration registers
  logic                                   en_own_tx_r, en_own_rx_r, en_cs_r, en_nav_r;
  logic signed [cbnt_pkg::RSS_W-1:0]      threshold_r;
  logic [cbnt_pkg::DUR_W-1:0]             short_gap_r;
  logic [cbnt_pkg::CNT_W-1:0]             period_r;

  // Tracking state
  logic                                   tx_active_r, tx_active_nxt;
  logic                                   rx_active_r, rx_active_nxt;
  logic signed [cbnt_pkg::RSS_W-1:0]      strength_r, strength_nxt;
  logic [cbnt_pkg::DUR_W-1:0]             nav_r, nav_nxt;
  logic                                   awaiting_r, awaiting_nxt;
  logic                                   prior_busy_r;
  logic [cbnt_pkg::CNT_W-1:0]             elapsed_r, elapsed_nxt;
  logic [cbnt_pkg::CNT_W-1:0]             busy_ticks_r, busy_ticks_nxt;

  // Output register
  logic                                   out_valid_r;
  logic                                   busy_r, changed_r, nav_started_r, nav_ended_r;
  logic [cbnt_pkg::ADDR48_W-1:0]          owner_r;
  logic                                   period_done_r;
  logic [cbnt_pkg::CNT_W-1:0]             count_r;

  logic                                   busy_nxt, nav_started_nxt, nav_ended_nxt;
  logic                                   period_done_nxt;
  logic [cbnt_pkg::ADDR48_W-1:0]          owner_nxt;
  logic [cbnt_pkg::CNT_W-1:0]             count_nxt;
  logic [cbnt_pkg::CNT_W-1:0]             limit;
  logic [cbnt_pkg::CNT_W-1:0]             elapsed_inc;
  logic [cbnt_pkg::CNT_W-1:0]             busy_inc;

  logic                                   in_fire;
  logic                                   cfg_wr;
  cbnt_pkg::reg_idx_t                     cfg_idx;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[cbnt_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_own_tx_r <= 1'b1;
      en_own_rx_r <= 1'b1;
      en_cs_r     <= 1'b1;
      en_nav_r    <= 1'b1;
      threshold_r <= cbnt_pkg::THRESHOLD_RST;
      short_gap_r <= cbnt_pkg::SHORT_GAP_RST;
      period_r    <= cbnt_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cbnt_pkg::REG_EN_OWN_TX: en_own_tx_r <= pwdata[0];
        cbnt_pkg::REG_EN_OWN_RX: en_own_rx_r <= pwdata[0];
        cbnt_pkg::REG_EN_CS:     en_cs_r     <= pwdata[0];
        cbnt_pkg::REG_EN_NAV:    en_nav_r    <= pwdata[0];
        cbnt_pkg::REG_THRESHOLD: threshold_r <= signed'(pwdata[cbnt_pkg::RSS_W-1:0]);
        cbnt_pkg::REG_SHORT_GAP: short_gap_r <= pwdata[cbnt_pkg::DUR_W-1:0];
        cbnt_pkg::REG_PERIOD:    period_r    <= pwdata[cbnt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cbnt_pkg::REG_EN_OWN_TX: prdata = {31'd0, en_own_tx_r};
      cbnt_pkg::REG_EN_OWN_RX: prdata = {31'd0, en_own_rx_r};
      cbnt_pkg::REG_EN_CS:     prdata = {31'd0, en_cs_r};
      cbnt_pkg::REG_EN_NAV:    prdata = {31'd0, en_nav_r};
      cbnt_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_r};
      cbnt_pkg::REG_SHORT_GAP: prdata = {16'd0, short_gap_r};
      cbnt_pkg::REG_PERIOD:    prdata = period_r;
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Event processing
  // ---------------------------------------------------------------------------
  assign limit       = (period_r == '0) ? 32'd1 : period_r;
  assign elapsed_inc = elapsed_r + 32'd1;
  assign busy_inc    = (prior_busy_r && busy_ticks_r != '1) ? busy_ticks_r + 32'd1
                                                            : busy_ticks_r;

  always_comb begin
    tx_active_nxt   = tx_active_r;
    rx_active_nxt   = rx_active_r;
    strength_nxt    = strength_r;
    nav_nxt         = nav_r;
    awaiting_nxt    = awaiting_r;
    elapsed_nxt     = elapsed_r;
    busy_ticks_nxt  = busy_ticks_r;
    nav_started_nxt = 1'b0;
    nav_ended_nxt   = 1'b0;
    owner_nxt       = '0;
    period_done_nxt = 1'b0;
    count_nxt       = '0;

    case (in_operation)
      cbnt_pkg::OP_TICK: begin
        busy_ticks_nxt = busy_inc;
        if (nav_r != '0) begin
          nav_nxt = nav_r - 16'd1;
          if (nav_r == 16'd1) begin
            nav_ended_nxt = 1'b1;
            awaiting_nxt  = 1'b0;
          end
        end
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= limit) begin
          period_done_nxt = 1'b1;
          count_nxt       = busy_inc;
          busy_ticks_nxt  = '0;
          elapsed_nxt     = '0;
        end
      end
      cbnt_pkg::OP_TX_START: tx_active_nxt = 1'b1;
      cbnt_pkg::OP_TX_END: begin
        tx_active_nxt = 1'b0;
        // Own NAV: covers the expected reply, never signalled as started.
        if (in_duration > short_gap_r && in_has_payload && in_duration > nav_r) begin
          nav_nxt      = in_duration;
          awaiting_nxt = 1'b1;
        end
      end
      cbnt_pkg::OP_RX_START: rx_active_nxt = 1'b1;
      cbnt_pkg::OP_RX_END:   rx_active_nxt = 1'b0;
      cbnt_pkg::OP_FRAME_RX: begin
        if (in_ack_for_me) begin
          if (awaiting_r) begin
            nav_nxt      = '0;
            awaiting_nxt = 1'b0;
          end
        end else if (in_duration >= short_gap_r && in_duration > nav_r) begin
          nav_nxt         = in_duration;
          nav_started_nxt = 1'b1;
          owner_nxt       = in_sender_address;
        end
      end
      cbnt_pkg::OP_RSS_CHANGE: begin
        if (en_cs_r) strength_nxt = in_signal_strength;
      end
      default: ;
    endcase
  end

  assign busy_nxt = (en_own_tx_r & tx_active_nxt) |
                    (en_own_rx_r & rx_active_nxt) |
                    (en_cs_r & (strength_nxt > threshold_r)) |
                    (en_nav_r & (nav_nxt != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_active_r  <= 1'b0;
      rx_active_r  <= 1'b0;
      strength_r   <= cbnt_pkg::RSS_RST;
      nav_r        <= '0;
      awaiting_r   <= 1'b0;
      prior_busy_r <= 1'b0;
      elapsed_r    <= '0;
      busy_ticks_r <= '0;
    end else if (in_fire) begin
      tx_active_r  <= tx_active_nxt;
      rx_active_r  <= rx_active_nxt;
      strength_r   <= strength_nxt;
      nav_r        <= nav_nxt;
      awaiting_r   <= awaiting_nxt;
      prior_busy_r <= busy_nxt;
      elapsed_r    <= elapsed_nxt;
      busy_ticks_r <= busy_ticks_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      busy_r        <= busy_nxt;
      changed_r     <= busy_nxt ^ prior_busy_r;
      nav_started_r <= nav_started_nxt;
      nav_ended_r   <= nav_ended_nxt;
      owner_r       <= owner_nxt;
      period_done_r <= period_done_nxt;
      count_r       <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_busy  = busy_r;
  assign out_state_changed = changed_r;
  assign out_nav_started   = nav_started_r;
  assign out_nav_ended     = nav_ended_r;
  assign out_nav_owner     = owner_r;
  assign out_period_done   = period_done_r;
  assign out_busy_count    = count_r;

`ifndef SYNTHESIS
  // Waiting for a reply always comes with a running NAV.
  a_await_nav: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> nav_r != '0)
    else $error("awaiting reply without a running NAV");

  // Busy ticks can never outnumber elapsed ticks within a period.
  a_busy_le_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    busy_ticks_r <= elapsed_r)
    else $error("busy tick count exceeds elapsed ticks");

  // The held result carries the channel state that the tracker last recorded.
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r == prior_busy_r)
    else $error("result channel state differs from tracked state");

  // A NAV that ends on a tick leaves the countdown at zero.
  a_nav_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && nav_ended_nxt) |=> nav_r == '0 && !awaiting_r)
    else $error("NAV end reported with NAV still running");

  // The owner field is only filled when a received frame raised the NAV.
  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !nav_started_r) |-> owner_r == '0)
    else $error("NAV owner set without NAV start");
`endif

endmodule
